### hdl/abac_pkg.sv
// abac_pkg: shared types and constants of the approach brake angle controller
// used by abac_cfg, abac_ctrl, abac_dp and the top level; no dependencies
`default_nettype none

package abac_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_TICK_INTERVAL  = 3'd0;
	localparam logic [2:0] REG_RELEASE_ANGLE  = 3'd1;
	localparam logic [2:0] REG_FULL_ANGLE     = 3'd2;
	localparam logic [2:0] REG_LONG_STOP      = 3'd3;
	localparam logic [2:0] REG_IMMEDIATE_STOP = 3'd4;
	localparam logic [2:0] REG_REQUIRED       = 3'd5;
	localparam logic [2:0] REG_HOLD_TIME      = 3'd6;
	localparam logic [2:0] REG_RAMP_TIME      = 3'd7;

	// register reset values
	localparam logic [15:0] TICK_RESET      = 16'd100;
	localparam logic [7:0]  RELEASE_RESET   = 8'd90;
	localparam logic [7:0]  FULL_RESET      = 8'd0;
	localparam logic [15:0] LONG_RESET      = 16'd10;
	localparam logic [15:0] IMMEDIATE_RESET = 16'd3;
	localparam logic [15:0] REQUIRED_RESET  = 16'd2;
	localparam logic [31:0] HOLD_RESET      = 32'd2000;
	localparam logic [31:0] RAMP_RESET      = 32'd1000;

	// request widths
	localparam int IN_BYTES  = 11;
	localparam int OUT_BYTES = 5;

	typedef struct packed {
		logic [15:0] tick_interval;
		logic [7:0]  release_angle;
		logic [7:0]  full_angle;
		logic [15:0] long_stop_frames;
		logic [15:0] immediate_stop_frames;
		logic [15:0] required_frames;
		logic [31:0] hold_time;
		logic [31:0] ramp_time;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic eval;
		logic angle;
		logic div_init;
		logic div_step;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

### hdl/abac_cfg.sv
// abac_cfg: configuration register file written through the config channel
// depends on abac_pkg
`default_nettype none

module abac_cfg
	import abac_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [31:0] wr_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_interval         <= TICK_RESET;
			cfg_q.release_angle         <= RELEASE_RESET;
			cfg_q.full_angle            <= FULL_RESET;
			cfg_q.long_stop_frames      <= LONG_RESET;
			cfg_q.immediate_stop_frames <= IMMEDIATE_RESET;
			cfg_q.required_frames       <= REQUIRED_RESET;
			cfg_q.hold_time             <= HOLD_RESET;
			cfg_q.ramp_time             <= RAMP_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TICK_INTERVAL:  cfg_q.tick_interval         <= wr_data[15:0];
				REG_RELEASE_ANGLE:  cfg_q.release_angle         <= wr_data[7:0];
				REG_FULL_ANGLE:     cfg_q.full_angle            <= wr_data[7:0];
				REG_LONG_STOP:      cfg_q.long_stop_frames      <= wr_data[15:0];
				REG_IMMEDIATE_STOP: cfg_q.immediate_stop_frames <= wr_data[15:0];
				REG_REQUIRED:       cfg_q.required_frames       <= wr_data[15:0];
				REG_HOLD_TIME:      cfg_q.hold_time             <= wr_data;
				REG_RAMP_TIME:      cfg_q.ramp_time             <= wr_data;
				default:            cfg_q.tick_interval         <= cfg_q.tick_interval;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hdl/abac_ctrl.sv
// abac_ctrl: sequencing state machine, one request at a time
// depends on abac_pkg; drives commands into abac_dp
`default_nettype none

module abac_ctrl
	import abac_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_ANGLE = 3'd2;
	localparam logic [2:0] ST_DINIT = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_ANGLE;
			end
			ST_ANGLE: begin
				cmd.angle = 1'b1;
				state_d   = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = sts.need_div ? ST_DIV : ST_FIN;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### hdl/abac_dp.sv
// abac_dp: evaluation state, angle selection, ramp divider and output register
// depends on abac_pkg; commanded by abac_ctrl
`default_nettype none

module abac_dp
	import abac_pkg::*;
#(
	parameter int SERVO_LOW  = 0,
	parameter int SERVO_HIGH = 180,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cfg_t                    cfg,
	input  wire cmd_t                    cmd,
	output sts_t                         sts,
	input  wire logic [IN_BYTES*8-1:0]   in_data,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [OUT_BYTES*8-1:0]       out_data
);

	localparam int CMPW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic signed [10:0] LOW_S  = 11'(SERVO_LOW);
	localparam logic signed [10:0] HIGH_S = 11'(SERVO_HIGH);

	// captured request
	logic [31:0] now_q;
	logic [7:0]  left_q;
	logic [7:0]  right_q;
	logic        np_q;
	logic [31:0] start_q;

	// controller state of the model
	logic [31:0]           last_eval_q;
	logic [7:0]            fused_q;
	logic [COUNT_BITS-1:0] app_cnt_q;
	logic [COUNT_BITS-1:0] fb_cnt_q;
	logic                  stop_valid_q;
	logic [31:0]           deadline_q;
	logic [7:0]            held_q;

	// per-request working registers
	logic [7:0]  angle_q;
	logic        hold_q;
	logic        ramp_full_q;
	logic        span_neg_q;
	logic [39:0] prod_q;
	logic [31:0] rem_q;
	logic [7:0]  shift_q;
	logic [7:0]  quo_q;
	logic [2:0]  step_q;
	logic        out_valid_q;
	logic [OUT_BYTES*8-1:0] out_q;

	// evaluation terms
	logic [31:0]           since_eval;
	logic                  do_eval;
	logic [7:0]            fused_n;
	logic [COUNT_BITS-1:0] app_inc;
	logic [COUNT_BITS-1:0] fb_inc;
	logic                  approach;
	logic                  at_full;
	logic                  sv_set;

	assign since_eval = now_q - last_eval_q;
	assign do_eval    = since_eval >= {16'd0, cfg.tick_interval};
	assign fused_n    = (left_q < right_q) ? left_q : right_q;
	assign app_inc    = (app_cnt_q == CNT_MAX) ? app_cnt_q : app_cnt_q + 1'b1;
	assign fb_inc     = (fb_cnt_q == CNT_MAX) ? fb_cnt_q : fb_cnt_q + 1'b1;
	assign approach   = fused_n < cfg.release_angle;
	assign at_full    = fused_n == cfg.full_angle;
	assign sv_set     = ((fused_n > cfg.full_angle) &&
	                     (CMPW'(app_inc) >= CMPW'(cfg.long_stop_frames))) ||
	                    (at_full && (CMPW'(fb_inc) >= CMPW'(cfg.immediate_stop_frames)));

	// count of approach frames reaches the live-drive threshold
	logic        live;
	assign live = CMPW'(app_cnt_q) >= CMPW'(cfg.required_frames);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			now_q   <= in_data[31:0];
			left_q  <= in_data[39:32];
			right_q <= in_data[47:40];
			np_q    <= in_data[48];
			start_q <= in_data[80:49];
		end
	end

	// fused approach evaluation and angle hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_eval_q  <= '0;
			fused_q      <= RELEASE_RESET;
			app_cnt_q    <= '0;
			fb_cnt_q     <= '0;
			stop_valid_q <= 1'b0;
			deadline_q   <= '0;
			held_q       <= RELEASE_RESET;
		end else if (cmd.eval && do_eval) begin
			last_eval_q <= now_q;
			fused_q     <= fused_n;
			if (approach) begin
				app_cnt_q <= app_inc;
				fb_cnt_q  <= at_full ? fb_inc : '0;
				if (sv_set) begin
					stop_valid_q <= 1'b1;
				end
			end else begin
				if (stop_valid_q && live) begin
					deadline_q <= now_q + cfg.hold_time;
				end
				app_cnt_q    <= '0;
				fb_cnt_q     <= '0;
				stop_valid_q <= 1'b0;
			end
		end else if (cmd.angle && live) begin
			held_q <= fused_q;
		end
	end

	// ramp terms
	logic [31:0] elapsed;
	logic        span_neg;
	logic [7:0]  span_mag;
	assign elapsed  = now_q - start_q;
	assign span_neg = cfg.full_angle < cfg.release_angle;
	assign span_mag = span_neg ? (cfg.release_angle - cfg.full_angle)
	                           : (cfg.full_angle - cfg.release_angle);

	// divider step: quotient stays below 256 since elapsed < ramp_time
	logic [32:0] trial;
	logic        qbit;
	assign trial = {rem_q, shift_q[7]};
	assign qbit  = trial >= {1'b0, cfg.ramp_time};

	// angle selection, ramp product and divider
	always_ff @(posedge clk) begin
		if (cmd.angle) begin
			hold_q      <= now_q < deadline_q;
			angle_q     <= live ? fused_q :
			               ((now_q < deadline_q) ? held_q : cfg.release_angle);
			ramp_full_q <= elapsed >= cfg.ramp_time;
			span_neg_q  <= span_neg;
			prod_q      <= elapsed * span_mag;
		end
		if (cmd.div_init) begin
			rem_q   <= prod_q[39:8];
			shift_q <= prod_q[7:0];
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q   <= qbit ? 32'(trial - {1'b0, cfg.ramp_time}) : trial[31:0];
			shift_q <= {shift_q[6:0], 1'b0};
			quo_q   <= {quo_q[6:0], qbit};
		end
	end

	// step counter of the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_init) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	// ramp limit, minimum and servo clamp
	logic signed [10:0] lim;
	logic signed [10:0] ang_s;
	logic signed [10:0] sel;
	logic signed [10:0] clamped;
	logic [7:0]         brake;
	always_comb begin
		if (ramp_full_q) begin
			lim = 11'(cfg.full_angle);
		end else if (span_neg_q) begin
			lim = 11'(cfg.release_angle) - 11'(quo_q);
		end else begin
			lim = 11'(cfg.release_angle) + 11'(quo_q);
		end
		ang_s = 11'(angle_q);
		sel   = (np_q && (lim < ang_s)) ? lim : ang_s;
		if (sel < LOW_S) begin
			clamped = LOW_S;
		end else if (sel > HIGH_S) begin
			clamped = HIGH_S;
		end else begin
			clamped = sel;
		end
		brake = clamped[7:0];
	end

	logic [CMPW-1:0] app_ext;
	assign app_ext = CMPW'(app_cnt_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= {7'd0, hold_q, app_ext[15:0], fused_q, brake};
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_q;
	assign sts.need_div = np_q && !ramp_full_q;
	assign sts.div_last = step_q == 3'd7;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

### hdl/approach_brake_angle_controller.sv
// approach_brake_angle_controller: top level, config registers, controller, datapath
// sequence: request accept, evaluation, angle select, divider init, then the finish state
// loads the result register once it is free; the no-pulse ramp adds its 8-step serial
// divide before finish; one request in flight, so a new request is taken only after the last
// is loaded, and the result register lets the next request in while a result waits
// reset: arst_n asynchronous active low, registers back to defaults, angles at 90
`default_nettype none

module approach_brake_angle_controller
	import abac_pkg::*;
#(
	parameter int SERVO_LOW  = 0,
	parameter int SERVO_HIGH = 180,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// now_ms[31:0], left_angle[39:32], right_angle[47:40], no_pulse[48],
	// response_start_ms[80:49], zero fill
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_BYTES*8-1:0] s_axis_tdata,
	// brake_angle[7:0], fused_angle[15:8], approach_frames[31:16],
	// hold_active[32], zero fill
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_BYTES*8-1:0]     m_axis_tdata,
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [31:0]           cfg_data
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	abac_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	abac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	abac_dp #(
		.SERVO_LOW  (SERVO_LOW),
		.SERVO_HIGH (SERVO_HIGH),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench: directed and random requests into approach_brake_angle_controller, each result
// checked field by field against a predictor of the evaluation, hold and no-pulse ramp logic
// depends on abac_pkg and approach_brake_angle_controller

module testbench;
	import abac_pkg::*;

	localparam int ANGLE_MIN = 0;
	localparam int ANGLE_MAX = 180;
	localparam logic [15:0] FRAMES_MAX = 16'hFFFF;
	localparam int GAP_MAX = 19;
	localparam int SHOWN_MISMATCHES = 40;

	// laid out as on the result bus, brake angle in the lowest bits
	typedef struct packed {
		logic        hold_active;
		logic [15:0] approach_frames;
		logic [7:0]  fused_angle;
		logic [7:0]  brake_angle;
	} brake_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	wire                   s_axis_tready;
	logic [IN_BYTES*8-1:0] s_axis_tdata;
	wire                   m_axis_tvalid;
	logic                  m_axis_tready;
	wire [OUT_BYTES*8-1:0] m_axis_tdata;
	logic                  cfg_valid;
	wire                   cfg_ready;
	logic [2:0]            cfg_index;
	logic [31:0]           cfg_data;

	// predictor copy of registers and controller state
	cfg_t        regs_now;
	logic [31:0] eval_stamp;
	logic [31:0] hold_until;
	logic [7:0]  fused_now;
	logic [7:0]  held_now;
	logic [15:0] approach_cnt;
	logic [15:0] full_cnt;
	logic        stop_ok;

	brake_result_t expected_results[$];
	int unsigned   mismatch_count = 0;
	int unsigned   calls_sent = 0;
	logic [31:0]   clock_ms = 32'd0;
	logic          idle_allowed = 1'b1;
	logic          source_gaps = 1'b1;
	logic          sink_stalls = 1'b1;

	approach_brake_angle_controller uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [15:0] sat_bump(input logic [15:0] count);
		return (count == FRAMES_MAX) ? count : count + 16'd1;
	endfunction

	// expected result of one request, advances the predictor state
	function automatic brake_result_t predict_call(input logic [31:0] now,
			input logic [7:0] left, input logic [7:0] right, input logic no_pulse,
			input logic [31:0] start);
		brake_result_t res;
		logic [31:0] since;
		logic [31:0] elapsed;
		logic hold;
		longint angle;
		longint limit;
		longint span;
		since = now - eval_stamp;
		// periodic evaluation of the fused angle
		if (since >= 32'(regs_now.tick_interval)) begin
			eval_stamp = now;
			fused_now = (left < right) ? left : right;
			if (fused_now < regs_now.release_angle) begin
				approach_cnt = sat_bump(approach_cnt);
				full_cnt = (fused_now == regs_now.full_angle) ? sat_bump(full_cnt) : 16'd0;
				if (fused_now > regs_now.full_angle &&
						approach_cnt >= regs_now.long_stop_frames)
					stop_ok = 1'b1;
				if (fused_now == regs_now.full_angle &&
						full_cnt >= regs_now.immediate_stop_frames)
					stop_ok = 1'b1;
			end else begin
				if (stop_ok && approach_cnt >= regs_now.required_frames)
					hold_until = now + regs_now.hold_time;
				approach_cnt = 16'd0;
				full_cnt = 16'd0;
				stop_ok = 1'b0;
			end
		end
		// held, released or live angle
		hold = now < hold_until;
		angle = hold ? longint'(held_now) : longint'(regs_now.release_angle);
		if (approach_cnt >= regs_now.required_frames) begin
			angle = longint'(fused_now);
			held_now = fused_now;
		end
		// no-pulse ramp limit, quotient truncated toward zero
		if (no_pulse) begin
			elapsed = now - start;
			if (elapsed >= regs_now.ramp_time) begin
				limit = $signed({56'd0, regs_now.full_angle});
			end else begin
				span = $signed({56'd0, regs_now.full_angle}) -
					$signed({56'd0, regs_now.release_angle});
				limit = $signed({56'd0, regs_now.release_angle}) +
					($signed({32'd0, elapsed}) * span) / $signed({32'd0, regs_now.ramp_time});
			end
			if (limit < angle)
				angle = limit;
		end
		if (angle < ANGLE_MIN)
			angle = longint'(ANGLE_MIN);
		if (angle > ANGLE_MAX)
			angle = longint'(ANGLE_MAX);
		res.brake_angle = angle[7:0];
		res.fused_angle = fused_now;
		res.approach_frames = approach_cnt;
		res.hold_active = hold;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= SHOWN_MISMATCHES)
			$display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// one request on the input stream, then a random gap
	task automatic send_call(input logic [31:0] now, input logic [7:0] left,
			input logic [7:0] right, input logic no_pulse, input logic [31:0] start);
		int gap;
		s_axis_tdata <= {7'd0, start, no_pulse, right, left, now};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		expected_results.push_back(predict_call(now, left, right, no_pulse, start));
		calls_sent++;
		gap = (idle_allowed && source_gaps) ? $urandom_range(0, GAP_MAX) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and let every pending result come back
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
		cfg_index <= index;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (index)
			REG_TICK_INTERVAL:  regs_now.tick_interval = value[15:0];
			REG_RELEASE_ANGLE:  regs_now.release_angle = value[7:0];
			REG_FULL_ANGLE:     regs_now.full_angle = value[7:0];
			REG_LONG_STOP:      regs_now.long_stop_frames = value[15:0];
			REG_IMMEDIATE_STOP: regs_now.immediate_stop_frames = value[15:0];
			REG_REQUIRED:       regs_now.required_frames = value[15:0];
			REG_HOLD_TIME:      regs_now.hold_time = value;
			REG_RAMP_TIME:      regs_now.ramp_time = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_config(input cfg_t c);
		wait_idle();
		write_reg(REG_TICK_INTERVAL, 32'(c.tick_interval));
		write_reg(REG_RELEASE_ANGLE, 32'(c.release_angle));
		write_reg(REG_FULL_ANGLE, 32'(c.full_angle));
		write_reg(REG_LONG_STOP, 32'(c.long_stop_frames));
		write_reg(REG_IMMEDIATE_STOP, 32'(c.immediate_stop_frames));
		write_reg(REG_REQUIRED, 32'(c.required_frames));
		write_reg(REG_HOLD_TIME, c.hold_time);
		write_reg(REG_RAMP_TIME, c.ramp_time);
	endtask

	function automatic logic [31:0] corner_pick(input logic [31:0] top, input int unsigned mid);
		case ($urandom_range(0, 2))
			0: return 32'd0;
			1: return top;
			default: return $urandom_range(0, mid);
		endcase
	endfunction

	function automatic cfg_t random_profile(input int kind);
		cfg_t c;
		c.tick_interval = TICK_RESET;
		c.release_angle = RELEASE_RESET;
		c.full_angle = FULL_RESET;
		c.long_stop_frames = LONG_RESET;
		c.immediate_stop_frames = IMMEDIATE_RESET;
		c.required_frames = REQUIRED_RESET;
		c.hold_time = HOLD_RESET;
		c.ramp_time = RAMP_RESET;
		case (kind)
			// fast ticks and short windows, ordered angles
			1: begin
				c.tick_interval = 16'($urandom_range(0, 5));
				c.release_angle = 8'($urandom_range(60, 180));
				c.full_angle = 8'($urandom_range(0, 30));
				c.long_stop_frames = 16'($urandom_range(1, 8));
				c.immediate_stop_frames = 16'($urandom_range(0, 4));
				c.required_frames = 16'($urandom_range(0, 4));
				c.hold_time = $urandom_range(0, 400);
				c.ramp_time = $urandom_range(1, 600);
			end
			// full brake angle at or above release
			2: begin
				c.tick_interval = 16'($urandom_range(0, 50));
				c.release_angle = 8'($urandom_range(0, 90));
				c.full_angle = 8'($urandom_range(c.release_angle, 180));
				c.long_stop_frames = 16'($urandom_range(0, 6));
				c.immediate_stop_frames = 16'($urandom_range(0, 3));
				c.required_frames = 16'($urandom_range(0, 3));
				c.hold_time = $urandom_range(0, 3000);
				c.ramp_time = $urandom_range(0, 3000);
			end
			// register extremes
			3: begin
				c.tick_interval = 16'(corner_pick(32'hFFFF, 20));
				c.release_angle = 8'(corner_pick(32'd180, 180));
				c.full_angle = 8'(corner_pick(32'd180, 180));
				c.long_stop_frames = 16'(corner_pick(32'hFFFF, 6));
				c.immediate_stop_frames = 16'(corner_pick(32'hFFFF, 6));
				c.required_frames = 16'(corner_pick(32'hFFFF, 6));
				c.hold_time = corner_pick(32'hFFFF_FFFF, 3000);
				c.ramp_time = corner_pick(32'hFFFF_FFFF, 3000);
			end
			default: ;
		endcase
		return c;
	endfunction

	// advance the millisecond clock and send a sensor pair whose minimum is the target
	task automatic send_target(input logic [7:0] target);
		logic [31:0] tick;
		logic [31:0] advance;
		logic [31:0] elapsed;
		logic [7:0] other;
		logic no_pulse;
		if ($urandom_range(0, 49) == 0)
			source_gaps = ($urandom_range(0, 2) != 0);
		tick = 32'(regs_now.tick_interval);
		case ($urandom_range(0, 9))
			0: advance = $urandom_range(0, 5000);
			1: advance = tick;
			default: advance = $urandom_range(0, tick + tick / 2 + 3);
		endcase
		clock_ms += advance;
		other = 8'($urandom_range(target, 255));
		no_pulse = ($urandom_range(0, 2) == 0);
		if ($urandom_range(0, 3) == 0)
			elapsed = $urandom();
		else
			elapsed = $urandom_range(0, regs_now.ramp_time);
		if ($urandom_range(0, 1) != 0)
			send_call(clock_ms, target, other, no_pulse, clock_ms - elapsed);
		else
			send_call(clock_ms, other, target, no_pulse, clock_ms - elapsed);
	endtask

	// approach, clear and coast sequences with some noise mixed in
	task automatic run_episodes(input int unsigned calls);
		int unsigned goal;
		int k;
		logic [7:0] rel;
		logic [7:0] full;
		logic [7:0] target;
		goal = calls_sent + calls;
		while (calls_sent < goal) begin
			rel = regs_now.release_angle;
			full = regs_now.full_angle;
			// approach frames, often at exactly full brake
			k = $urandom_range(1, 14);
			repeat (k) begin
				if (rel == 8'd0)
					target = 8'($urandom_range(0, 255));
				else if (full < rel && $urandom_range(0, 2) == 0)
					target = full;
				else
					target = 8'($urandom_range(0, rel - 1));
				send_target(target);
			end
			// approach clears
			k = $urandom_range(1, 5);
			repeat (k) send_target(8'($urandom_range(rel, 255)));
			// right at the hold deadline
			if ($urandom_range(0, 2) == 0 && (hold_until - clock_ms) < 32'd10000) begin
				clock_ms = hold_until - $urandom_range(0, 1);
				send_call(clock_ms, 8'd255, 8'd255, 1'b0, clock_ms);
			end
			// unrelated requests
			if ($urandom_range(0, 3) == 0) begin
				k = $urandom_range(1, 3);
				repeat (k) send_call($urandom(), 8'($urandom()), 8'($urandom()),
					1'($urandom_range(0, 1)), $urandom());
			end
		end
	endtask

	// reset values: first evaluation, full brake stop, hold window and ramp
	task automatic test_reset_defaults();
		send_call(32'd0, 8'd120, 8'd130, 1'b0, 32'd0);
		send_call(32'd100, 8'd50, 8'd60, 1'b0, 32'd0);
		send_call(32'd200, 8'd0, 8'd255, 1'b0, 32'd0);
		send_call(32'd300, 8'd0, 8'd0, 1'b0, 32'd0);
		send_call(32'd399, 8'd0, 8'd0, 1'b0, 32'd0);
		send_call(32'd400, 8'd0, 8'd0, 1'b0, 32'd0);
		// clear arms the hold until 2500
		send_call(32'd500, 8'd200, 8'd150, 1'b0, 32'd0);
		send_call(32'd2499, 8'd255, 8'd255, 1'b0, 32'd0);
		send_call(32'd2500, 8'd255, 8'd255, 1'b0, 32'd0);
		// ramp halfway, at its start, one ms short of its end, and past it by wrap
		send_call(32'd2600, 8'd255, 8'd255, 1'b1, 32'd2100);
		send_call(32'd2601, 8'd255, 8'd255, 1'b1, 32'd2601);
		send_call(32'd2602, 8'd255, 8'd255, 1'b1, 32'd1603);
		send_call(32'd2603, 8'd255, 8'd255, 1'b1, 32'd2604);
		send_call(32'hFFFF_FFFF, 8'd255, 8'd255, 1'b1, 32'hFFFF_FFFF);
	endtask

	// zero interval, zero frame thresholds, deadline wrap, zero ramp, clamp
	task automatic test_corner_settings();
		cfg_t c;
		c = '{16'd0, 8'd180, 8'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'd0};
		apply_config(c);
		send_call(32'hFFFF_FFFF, 8'd3, 8'd7, 1'b0, 32'd0);
		send_call(32'd0, 8'd255, 8'd200, 1'b0, 32'd0);
		send_call(32'd1, 8'd0, 8'd0, 1'b1, 32'd1);
		send_call(32'd2, 8'd181, 8'd255, 1'b0, 32'd0);
	endtask

	// full brake angle above release, widest interval, ramp over the whole time range
	task automatic test_misordered_angles();
		cfg_t c;
		logic [31:0] t;
		c = '{16'hFFFF, 8'd20, 8'd150, FRAMES_MAX, FRAMES_MAX, FRAMES_MAX, 32'd0,
			32'hFFFF_FFFF};
		apply_config(c);
		t = eval_stamp + 32'hFFFF;
		send_call(t, 8'd10, 8'd200, 1'b1, t - 32'h8000_0000);
		send_call(t + 32'd1, 8'd10, 8'd10, 1'b1, t + 32'd1 - 32'hFFFF_FFFE);
		t = t + 32'hFFFF;
		send_call(t, 8'd150, 8'd150, 1'b1, t + 32'd1);
		send_call(t + 32'd1, 8'd255, 8'd0, 1'b0, 32'd0);
	endtask

	task automatic test_random_traffic();
		cfg_t c;
		clock_ms = eval_stamp;
		for (int phase = 0; phase < 6; phase++) begin
			c = random_profile(phase % 4);
			apply_config(c);
			if (phase % 4 == 3)
				clock_ms = $urandom();
			run_episodes(110);
		end
	endtask

	// long back to back full brake run past every threshold, then the stop holds
	task automatic test_long_approach();
		cfg_t c;
		c = '{16'd0, 8'd180, 8'd0, 16'd40, 16'd30, 16'd20, 32'd1000, 32'd1000};
		apply_config(c);
		idle_allowed = 1'b0;
		clock_ms = 32'd1000;
		repeat (50) begin
			clock_ms++;
			send_call(clock_ms, 8'd0, 8'($urandom_range(0, 255)), 1'b0, 32'd0);
		end
		send_call(clock_ms + 32'd1, 8'd200, 8'd255, 1'b0, 32'd0);
		send_call(clock_ms + 32'd500, 8'd255, 8'd255, 1'b1, clock_ms);
		idle_allowed = 1'b1;
	endtask

	// result checker
	initial begin : result_sink
		int stall;
		brake_result_t got;
		brake_result_t want;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 49) == 0)
				sink_stalls = ($urandom_range(0, 2) != 0);
			stall = (idle_allowed && sink_stalls) ? $urandom_range(0, GAP_MAX) : 0;
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			got = brake_result_t'(m_axis_tdata[32:0]);
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing pending", m_axis_tdata[31:0], 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (got.brake_angle !== want.brake_angle)
					report_mismatch("brake_angle", 32'(got.brake_angle),
						32'(want.brake_angle));
				if (got.fused_angle !== want.fused_angle)
					report_mismatch("fused_angle", 32'(got.fused_angle),
						32'(want.fused_angle));
				if (got.approach_frames !== want.approach_frames)
					report_mismatch("approach_frames", 32'(got.approach_frames),
						32'(want.approach_frames));
				if (got.hold_active !== want.hold_active)
					report_mismatch("hold_active", 32'(got.hold_active),
						32'(want.hold_active));
			end
		end
	end

	initial begin : stimulus
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_TICK_INTERVAL;
		cfg_data <= 32'd0;
		arst_n <= 1'b0;
		// predictor state after reset
		regs_now = '{TICK_RESET, RELEASE_RESET, FULL_RESET, LONG_RESET, IMMEDIATE_RESET,
			REQUIRED_RESET, HOLD_RESET, RAMP_RESET};
		eval_stamp = 32'd0;
		hold_until = 32'd0;
		fused_now = RELEASE_RESET;
		held_now = RELEASE_RESET;
		approach_cnt = 16'd0;
		full_cnt = 16'd0;
		stop_ok = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_corner_settings();
		test_misordered_angles();
		test_random_traffic();
		test_long_approach();

		wait_idle();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("PASS approach_brake_angle_controller");
		else
			$display("FAIL approach_brake_angle_controller");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#5_000_000;
		$display("FAIL approach_brake_angle_controller");
		$finish;
	end

endmodule
